FILE: hdl/iia_pkg.sv
// Shared types, codes and constants of the iterative intercept aim point block.
package iia_pkg;

    localparam int MAX_ITER_DEFAULT = 16;
    localparam int SQRT_STEPS       = 34;   // root bits of a 68-bit radicand
    localparam int DIV_STEPS        = 50;   // quotient bits of distance << 16
    localparam int STEP_W           = 6;

    localparam logic [7:0] CFG_ITER = 8'd0;
    localparam logic [7:0] CFG_LEAD = 8'd1;

    localparam logic [4:0]  ITER_RESET = 5'd3;
    localparam logic [15:0] LEAD_RESET = 16'd256;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ZERO = 2'd1;
    localparam logic [1:0] STAT_SAT  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_SCALE,
        ST_OFF,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       sq_en;
        logic       off_en;
        logic [1:0] idx;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       scale;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic       speed_zero;
        logic [4:0] iter_cfg;
        logic       out_free;
    } sts_t;

endpackage

FILE: hdl/iia_ctrl.sv
// Controller state machine: sequences the squares, root, division, scaling and offsets.
module iia_ctrl #(
    parameter int MAX_ITERATIONS = iia_pkg::MAX_ITER_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  iia_pkg::sts_t sts,
    output iia_pkg::cmd_t cmd
);
    import iia_pkg::*;

    localparam int RW = $clog2(MAX_ITERATIONS + 1);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RW-1:0]     round_reg, round_next;
    logic [RW-1:0]     limit_reg, limit_next;
    logic [RW-1:0]     limit_in;
    logic              accept;

    assign accept = s_valid && s_ready;

    always_comb begin
        if (int'(sts.iter_cfg) > MAX_ITERATIONS) begin
            limit_in = RW'(MAX_ITERATIONS);
        end else begin
            limit_in = RW'(sts.iter_cfg);
        end
    end

    // next state and counters
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        round_next = round_reg;
        limit_next = limit_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    limit_next = limit_in;
                    round_next = '0;
                    step_next  = '0;
                    if (sts.speed_zero || limit_in == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SQ;
                    end
                end
            end
            ST_SQ: begin
                if (step_reg == STEP_W'(3)) begin
                    step_next  = '0;
                    state_next = ST_SQRT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_SQRT: begin
                if (step_reg == STEP_W'(SQRT_STEPS)) begin
                    step_next  = '0;
                    state_next = ST_DIV;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DIV: begin
                if (step_reg == STEP_W'(DIV_STEPS)) begin
                    step_next  = '0;
                    state_next = ST_SCALE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_SCALE: begin
                state_next = ST_OFF;
            end
            ST_OFF: begin
                if (step_reg == STEP_W'(3)) begin
                    step_next  = '0;
                    round_next = round_reg + 1'b1;
                    if (round_reg + 1'b1 == limit_reg) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SQ;
                    end
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        cmd       = '0;
        s_ready   = 1'b0;
        cmd.idx   = step_reg[1:0];
        case (state_reg)
            ST_IDLE:  begin
                s_ready  = 1'b1;
                cmd.load = accept;
            end
            ST_SQ:    cmd.sq_en = 1'b1;
            ST_SQRT:  begin
                cmd.sqrt_init = (step_reg == '0);
                cmd.sqrt_step = (step_reg != '0);
            end
            ST_DIV:   begin
                cmd.div_init = (step_reg == '0);
                cmd.div_step = (step_reg != '0);
            end
            ST_SCALE: cmd.scale = 1'b1;
            ST_OFF:   cmd.off_en = 1'b1;
            ST_DONE:  cmd.emit = sts.out_free;
            default:  cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            round_reg <= '0;
            limit_reg <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            round_reg <= round_next;
            limit_reg <= limit_next;
        end
    end

endmodule

FILE: hdl/iia_dp.sv
// Datapath: operand store, shared multiplier, bit-serial root and divider, output register.
module iia_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  iia_pkg::cmd_t       cmd,
    output iia_pkg::sts_t       sts,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic signed [31:0]  s_target_x,
    input  logic signed [31:0]  s_target_y,
    input  logic signed [31:0]  s_target_z,
    input  logic signed [31:0]  s_target_vel_x,
    input  logic signed [31:0]  s_target_vel_y,
    input  logic signed [31:0]  s_target_vel_z,
    input  logic signed [31:0]  s_shooter_x,
    input  logic signed [31:0]  s_shooter_y,
    input  logic signed [31:0]  s_shooter_z,
    input  logic [31:0]         s_projectile_speed,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_aim_x,
    output logic signed [31:0]  m_aim_y,
    output logic signed [31:0]  m_aim_z,
    output logic [1:0]          m_status
);
    import iia_pkg::*;

    logic [4:0]         iter_reg;
    logic [15:0]        lead_reg;
    logic signed [31:0] tgt_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] sh_reg  [3];
    logic signed [31:0] aim_reg [3];
    logic [31:0]        speed_reg;
    logic               zero_reg, sat_reg;
    logic [65:0]        prod_reg;
    logic [65:0]        sum_reg;
    logic [67:0]        rad_reg;
    logic [35:0]        rrem_reg;
    logic [33:0]        root_reg;
    logic [49:0]        quot_reg;
    logic [31:0]        drem_reg;
    logic [31:0]        t_reg;
    logic               m_valid_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic [1:0]         ost_reg;

    logic signed [31:0] sel_aim, sel_sh, sel_vel, upd_tgt;
    logic signed [32:0] diff;
    logic [32:0]        dmag, vmag, mul_a, mul_b;
    logic [65:0]        mul_p;
    logic [37:0]        rsh, rtrial;
    logic [32:0]        dsh;
    logic [65:0]        scl_p;
    logic [47:0]        off;
    logic signed [49:0] vsum;
    logic [1:0]         upd_idx;

    always_comb begin
        case (cmd.idx)
            2'd1:    begin sel_aim = aim_reg[1]; sel_sh = sh_reg[1];
                           sel_vel = vel_reg[1]; end
            2'd2:    begin sel_aim = aim_reg[2]; sel_sh = sh_reg[2];
                           sel_vel = vel_reg[2]; end
            default: begin sel_aim = aim_reg[0]; sel_sh = sh_reg[0];
                           sel_vel = vel_reg[0]; end
        endcase
    end

    // offset of the previous index lands this cycle
    assign upd_idx = cmd.idx - 2'd1;
    always_comb begin
        case (upd_idx)
            2'd1:    upd_tgt = tgt_reg[1];
            2'd2:    upd_tgt = tgt_reg[2];
            default: upd_tgt = tgt_reg[0];
        endcase
    end

    assign diff  = 33'(sel_aim) - 33'(sel_sh);
    assign dmag  = diff[32] ? 33'(-diff) : 33'(diff);
    assign vmag  = sel_vel[31] ? -33'(sel_vel) : 33'(sel_vel);
    assign mul_a = cmd.sq_en ? dmag : vmag;
    assign mul_b = cmd.sq_en ? dmag : {1'b0, t_reg};
    assign mul_p = mul_a * mul_b;

    assign rsh    = {rrem_reg, rad_reg[67:66]};
    assign rtrial = {2'b00, root_reg, 2'b01};
    assign dsh    = {drem_reg, quot_reg[49]};
    assign scl_p  = quot_reg * lead_reg;

    logic signed [49:0] off_s;
    assign off   = prod_reg[63:16];
    assign off_s = signed'({2'b00, off});
    logic neg_upd;
    always_comb begin
        case (upd_idx)
            2'd1:    neg_upd = vel_reg[1][31];
            2'd2:    neg_upd = vel_reg[2][31];
            default: neg_upd = vel_reg[0][31];
        endcase
    end
    assign vsum = neg_upd ? 50'(upd_tgt) - off_s : 50'(upd_tgt) + off_s;

    assign sts.speed_zero = (s_projectile_speed == '0);
    assign sts.iter_cfg   = iter_reg;
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_reg <= ITER_RESET;
            lead_reg <= LEAD_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_ITER) begin
                iter_reg <= cfg_data[4:0];
            end else if (cfg_index == CFG_LEAD) begin
                lead_reg <= cfg_data[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            tgt_reg   <= '{s_target_x, s_target_y, s_target_z};
            aim_reg   <= '{s_target_x, s_target_y, s_target_z};
            vel_reg   <= '{s_target_vel_x, s_target_vel_y, s_target_vel_z};
            sh_reg    <= '{s_shooter_x, s_shooter_y, s_shooter_z};
            speed_reg <= s_projectile_speed;
            zero_reg  <= (s_projectile_speed == '0);
            sat_reg   <= 1'b0;
        end
        if ((cmd.sq_en || cmd.off_en) && cmd.idx != 2'd3) begin
            prod_reg <= mul_p;
        end
        if (cmd.sq_en) begin
            sum_reg <= (cmd.idx == 2'd0) ? '0 : sum_reg + prod_reg;
        end
        if (cmd.sqrt_init) begin
            rad_reg  <= {2'b00, sum_reg};
            rrem_reg <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg <= {rad_reg[65:0], 2'b00};
            if (rsh >= rtrial) begin
                rrem_reg <= 36'(rsh - rtrial);
                root_reg <= {root_reg[32:0], 1'b1};
            end else begin
                rrem_reg <= rsh[35:0];
                root_reg <= {root_reg[32:0], 1'b0};
            end
        end
        if (cmd.div_init) begin
            quot_reg <= {root_reg[33:0], 16'h0000};
            drem_reg <= '0;
        end else if (cmd.div_step) begin
            if (dsh >= {1'b0, speed_reg}) begin
                drem_reg <= 32'(dsh - {1'b0, speed_reg});
                quot_reg <= {quot_reg[48:0], 1'b1};
            end else begin
                drem_reg <= dsh[31:0];
                quot_reg <= {quot_reg[48:0], 1'b0};
            end
        end
        if (cmd.scale) begin
            if (|scl_p[65:40]) begin
                t_reg   <= 32'hFFFF_FFFF;
                sat_reg <= 1'b1;
            end else begin
                t_reg <= scl_p[39:8];
            end
        end
        if (cmd.off_en && cmd.idx != 2'd0) begin
            if (vsum > 50'sd2147483647) begin
                aim_reg[upd_idx] <= 32'sh7FFF_FFFF;
                sat_reg          <= 1'b1;
            end else if (vsum < -50'sd2147483648) begin
                aim_reg[upd_idx] <= 32'sh8000_0000;
                sat_reg          <= 1'b1;
            end else begin
                aim_reg[upd_idx] <= vsum[31:0];
            end
        end
        if (cmd.emit) begin
            ox_reg  <= aim_reg[0];
            oy_reg  <= aim_reg[1];
            oz_reg  <= aim_reg[2];
            ost_reg <= zero_reg ? STAT_ZERO : (sat_reg ? STAT_SAT : STAT_OK);
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_aim_x  = ox_reg;
    assign m_aim_y  = oy_reg;
    assign m_aim_z  = oz_reg;
    assign m_status = ost_reg;

endmodule

FILE: hdl/iterative_intercept_aim_point_top.sv
// Top level of the iterative intercept aim point block: controller plus datapath.
//
//  channel   direction  handshake             payload
//  s_        in         s_valid / s_ready     target, target velocity, shooter, speed
//  m_        out        m_valid / m_ready     aim_x, aim_y, aim_z, status
//  cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request at a time, run for N = min(iteration_count, MAX_ITERATIONS) rounds.
// Each round computes the squares, then the bit-serial root, the bit-serial divide,
// lead scaling and the offsets; the two serial units take most of each round.
// Zero speed or zero rounds skip the rounds and go straight to the result.
// aresetn is synchronous, active low; it clears control and restores the configuration registers.
// A result waits in its output register while m_ready is low; the next request
// is taken once the previous result has been handed to that register.
module iterative_intercept_aim_point_top #(
    parameter int MAX_ITERATIONS = iia_pkg::MAX_ITER_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_target_x,
    input  logic signed [31:0] s_target_y,
    input  logic signed [31:0] s_target_z,
    input  logic signed [31:0] s_target_vel_x,
    input  logic signed [31:0] s_target_vel_y,
    input  logic signed [31:0] s_target_vel_z,
    input  logic signed [31:0] s_shooter_x,
    input  logic signed [31:0] s_shooter_y,
    input  logic signed [31:0] s_shooter_z,
    input  logic [31:0]        s_projectile_speed,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_aim_x,
    output logic signed [31:0] m_aim_y,
    output logic signed [31:0] m_aim_z,
    output logic [1:0]         m_status
);
    import iia_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // register writes are always taken; unknown indexes drop silently
    assign cfg_ready = 1'b1;

    iia_ctrl #(
        .MAX_ITERATIONS(MAX_ITERATIONS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    iia_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_valid          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_target_x         (s_target_x),
        .s_target_y         (s_target_y),
        .s_target_z         (s_target_z),
        .s_target_vel_x     (s_target_vel_x),
        .s_target_vel_y     (s_target_vel_y),
        .s_target_vel_z     (s_target_vel_z),
        .s_shooter_x        (s_shooter_x),
        .s_shooter_y        (s_shooter_y),
        .s_shooter_z        (s_shooter_z),
        .s_projectile_speed (s_projectile_speed),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_aim_x            (m_aim_x),
        .m_aim_y            (m_aim_y),
        .m_aim_z            (m_aim_z),
        .m_status           (m_status)
    );

endmodule
